[rtl/core/hicdf_pkg.sv]
// Shared types, constants and the control program of the histogram sampler.
// No dependencies; used by the interfaces, the sequencer, the datapath and the top.
package hicdf_pkg;

  localparam int DEF_MAX_BINS      = 1024;
  localparam int DEF_FRACTION_BITS = 16;

  localparam int ACTION_W    = 2;
  localparam int COUNT_W     = 32;
  localparam int UNIFORM_W   = 32;
  localparam int OUT_INDEX_W = 10;
  localparam int OUT_FRAC_W  = 16;
  localparam int SUM_W       = 42;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd2;

  // datapath operations
  localparam int OP_W = 4;
  localparam logic [OP_W-1:0] OP_NOP        = 4'd0;
  localparam logic [OP_W-1:0] OP_LATCH      = 4'd1;
  localparam logic [OP_W-1:0] OP_MUL_LO     = 4'd2;
  localparam logic [OP_W-1:0] OP_MUL_HI     = 4'd3;
  localparam logic [OP_W-1:0] OP_READ_MID   = 4'd4;
  localparam logic [OP_W-1:0] OP_CMP_MID    = 4'd5;
  localparam logic [OP_W-1:0] OP_READ_BASE  = 4'd6;
  localparam logic [OP_W-1:0] OP_LOAD_BASE  = 4'd7;
  localparam logic [OP_W-1:0] OP_LOAD_WIDTH = 4'd8;
  localparam logic [OP_W-1:0] OP_DIV_STEP   = 4'd9;
  localparam logic [OP_W-1:0] OP_EMIT       = 4'd10;
  localparam logic [OP_W-1:0] OP_EMIT_EMPTY = 4'd11;
  localparam logic [OP_W-1:0] OP_UPDATE     = 4'd12;

  // sequencer jump kinds
  localparam int JMP_W = 3;
  localparam logic [JMP_W-1:0] J_NEXT      = 3'd0;
  localparam logic [JMP_W-1:0] J_GOTO      = 3'd1;
  localparam logic [JMP_W-1:0] J_IF_IDLE   = 3'd2;  // no item offered
  localparam logic [JMP_W-1:0] J_IF_NSAMP  = 3'd3;
  localparam logic [JMP_W-1:0] J_IF_EMPTY  = 3'd4;
  localparam logic [JMP_W-1:0] J_IF_SDONE  = 3'd5;
  localparam logic [JMP_W-1:0] J_IF_DMORE  = 3'd6;
  localparam logic [JMP_W-1:0] J_OUT_WAIT  = 3'd7;  // hold while output busy, else target

  // program steps
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_FETCH      = 4'd0;
  localparam logic [STEP_W-1:0] STEP_DECODE     = 4'd1;
  localparam logic [STEP_W-1:0] STEP_CHECK      = 4'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_LO     = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_HI     = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SEARCH     = 4'd5;
  localparam logic [STEP_W-1:0] STEP_COMPARE    = 4'd6;
  localparam logic [STEP_W-1:0] STEP_READ_BASE  = 4'd7;
  localparam logic [STEP_W-1:0] STEP_LOAD_BASE  = 4'd8;
  localparam logic [STEP_W-1:0] STEP_LOAD_WIDTH = 4'd9;
  localparam logic [STEP_W-1:0] STEP_DIVIDE     = 4'd10;
  localparam logic [STEP_W-1:0] STEP_EMIT       = 4'd11;
  localparam logic [STEP_W-1:0] STEP_EMIT_EMPTY = 4'd12;
  localparam logic [STEP_W-1:0] STEP_UPDATE     = 4'd13;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [JMP_W-1:0]  jmp;
    logic [STEP_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            load;
  } ctrl_t;

  typedef struct packed {
    logic is_sample;
    logic empty;
    logic search_done;
    logic div_more;
    logic out_free;
  } status_t;

  function automatic uword_t ucode(input logic [STEP_W-1:0] step);
    uword_t w;
    unique case (step)
      STEP_FETCH:      w = '{OP_LATCH,      J_IF_IDLE,  STEP_FETCH};
      STEP_DECODE:     w = '{OP_NOP,        J_IF_NSAMP, STEP_UPDATE};
      STEP_CHECK:      w = '{OP_NOP,        J_IF_EMPTY, STEP_EMIT_EMPTY};
      STEP_MUL_LO:     w = '{OP_MUL_LO,     J_NEXT,     STEP_FETCH};
      STEP_MUL_HI:     w = '{OP_MUL_HI,     J_NEXT,     STEP_FETCH};
      STEP_SEARCH:     w = '{OP_READ_MID,   J_IF_SDONE, STEP_READ_BASE};
      STEP_COMPARE:    w = '{OP_CMP_MID,    J_GOTO,     STEP_SEARCH};
      STEP_READ_BASE:  w = '{OP_READ_BASE,  J_NEXT,     STEP_FETCH};
      STEP_LOAD_BASE:  w = '{OP_LOAD_BASE,  J_NEXT,     STEP_FETCH};
      STEP_LOAD_WIDTH: w = '{OP_LOAD_WIDTH, J_NEXT,     STEP_FETCH};
      STEP_DIVIDE:     w = '{OP_DIV_STEP,   J_IF_DMORE, STEP_DIVIDE};
      STEP_EMIT:       w = '{OP_EMIT,       J_OUT_WAIT, STEP_FETCH};
      STEP_EMIT_EMPTY: w = '{OP_EMIT_EMPTY, J_OUT_WAIT, STEP_FETCH};
      STEP_UPDATE:     w = '{OP_UPDATE,     J_GOTO,     STEP_FETCH};
      default:         w = '{OP_NOP,        J_GOTO,     STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/hicdf_ifs.sv]
// Valid/ready channel interfaces for request items and result items.
// Depends on hicdf_pkg for field widths.
interface hicdf_in_if;
  logic                               valid;
  logic                               ready;
  logic [hicdf_pkg::ACTION_W-1:0]     action;
  logic [hicdf_pkg::COUNT_W-1:0]      bin_count;
  logic [hicdf_pkg::UNIFORM_W-1:0]    uniform_value;

  modport source(output valid, action, bin_count, uniform_value, input ready);
  modport sink(input valid, action, bin_count, uniform_value, output ready);
endinterface

interface hicdf_out_if;
  logic                               valid;
  logic                               ready;
  logic [hicdf_pkg::OUT_INDEX_W-1:0]  bin_index;
  logic [hicdf_pkg::OUT_FRAC_W-1:0]   bin_fraction;
  logic                               empty_table;

  modport source(output valid, bin_index, bin_fraction, empty_table, input ready);
  modport sink(input valid, bin_index, bin_fraction, empty_table, output ready);
endinterface

[rtl/core/hicdf_seq.sv]
// Microcode sequencer: step counter, program table lookup and jump logic.
// Depends on hicdf_pkg (program table, ctrl_t, status_t).
module hicdf_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  hicdf_pkg::status_t  status,
  output hicdf_pkg::ctrl_t    ctrl,
  output logic                ready
);

  logic [hicdf_pkg::STEP_W-1:0] pc;
  logic [hicdf_pkg::STEP_W-1:0] pc_next;
  hicdf_pkg::uword_t            word;

  assign word      = hicdf_pkg::ucode(pc);
  assign ready     = (pc == hicdf_pkg::STEP_FETCH);
  assign ctrl.op   = word.op;
  assign ctrl.load = ready && in_valid;

  always_comb begin
    unique case (word.jmp)
      hicdf_pkg::J_NEXT:     pc_next = pc + 1'b1;
      hicdf_pkg::J_GOTO:     pc_next = word.target;
      hicdf_pkg::J_IF_IDLE:  pc_next = !in_valid ? word.target : pc + 1'b1;
      hicdf_pkg::J_IF_NSAMP: pc_next = !status.is_sample ? word.target : pc + 1'b1;
      hicdf_pkg::J_IF_EMPTY: pc_next = status.empty ? word.target : pc + 1'b1;
      hicdf_pkg::J_IF_SDONE: pc_next = status.search_done ? word.target : pc + 1'b1;
      hicdf_pkg::J_IF_DMORE: pc_next = status.div_more ? word.target : pc + 1'b1;
      hicdf_pkg::J_OUT_WAIT: pc_next = status.out_free ? word.target : pc;
      default:               pc_next = hicdf_pkg::STEP_FETCH;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= hicdf_pkg::STEP_FETCH;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

[rtl/core/hicdf_datapath.sv]
// Datapath: cumulative-sum memory, scaling multiplier, search registers,
// restoring divider and the result register. Driven by hicdf_seq control words.
module hicdf_datapath #(
  parameter int MAX_BINS      = hicdf_pkg::DEF_MAX_BINS,
  parameter int FRACTION_BITS = hicdf_pkg::DEF_FRACTION_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  hicdf_pkg::ctrl_t                    ctrl,
  output hicdf_pkg::status_t                  status,
  input  logic [hicdf_pkg::ACTION_W-1:0]      action_in,
  input  logic [hicdf_pkg::COUNT_W-1:0]       count_in,
  input  logic [hicdf_pkg::UNIFORM_W-1:0]     uniform_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hicdf_pkg::OUT_INDEX_W-1:0]   out_index,
  output logic [hicdf_pkg::OUT_FRAC_W-1:0]    out_fraction,
  output logic                                out_empty
);

  localparam int SUM_W  = hicdf_pkg::SUM_W;
  localparam int IDX_W  = $clog2(MAX_BINS);
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int DCNT_W = $clog2(FRACTION_BITS);
  localparam int PROD_W = SUM_W + 16;

  logic [SUM_W-1:0] store [MAX_BINS];
  logic [SUM_W-1:0] rdata;
  logic [IDX_W-1:0] rd_addr;

  logic [hicdf_pkg::ACTION_W-1:0]  action;
  logic [hicdf_pkg::COUNT_W-1:0]   count;
  logic [hicdf_pkg::UNIFORM_W-1:0] uniform;

  logic [SUM_W-1:0]         total;
  logic [CNT_W-1:0]         loaded;
  logic [SUM_W-1:0]         acc;
  logic [SUM_W-1:0]         s;
  logic [IDX_W-1:0]         lo;
  logic [IDX_W-1:0]         hi;
  logic [IDX_W-1:0]         mid;
  logic [SUM_W-1:0]         base;
  logic [SUM_W-1:0]         width;
  logic [SUM_W-1:0]         rem;
  logic [FRACTION_BITS-1:0] q;
  logic [DCNT_W-1:0]        dcnt;
  logic                     ok;

  logic             full;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat;
  logic [15:0]      mul_b;
  logic [PROD_W-1:0] product;
  logic [PROD_W-1:0] hi_sum;
  logic [IDX_W:0]   mid_wide;
  logic [IDX_W-1:0] mid_c;
  logic [SUM_W-1:0] width_c;
  logic [SUM_W-1:0] rem_c;
  logic [SUM_W:0]   rem_sh;
  logic [SUM_W:0]   rem_diff;
  logic             out_free;

  assign full     = (loaded == CNT_W'(MAX_BINS));
  assign sum_wide = {1'b0, total} + (SUM_W + 1)'(count);
  assign sum_sat  = sum_wide[SUM_W] ? hicdf_pkg::SUM_MAX : sum_wide[SUM_W-1:0];

  // one 42x16 multiplier, used for the low then the high half of r
  assign mul_b   = (ctrl.op == hicdf_pkg::OP_MUL_HI) ? uniform[31:16] : uniform[15:0];
  assign product = total * mul_b;
  assign hi_sum  = product + PROD_W'(acc);

  assign mid_wide = {1'b0, lo} + {1'b0, hi} + (IDX_W + 1)'(1);
  assign mid_c    = mid_wide[IDX_W:1];

  assign width_c  = rdata - base;
  assign rem_c    = s - base;
  assign rem_sh   = {rem, 1'b0};
  assign rem_diff = rem_sh - {1'b0, width};

  assign out_free = !out_valid || out_ready;

  always_comb begin
    case (ctrl.op)
      hicdf_pkg::OP_READ_MID:  rd_addr = mid_c - 1'b1;
      hicdf_pkg::OP_READ_BASE: rd_addr = lo - 1'b1;  // wraps at lo == 0; base forced to zero
      default:                 rd_addr = lo;
    endcase
  end

  assign status.is_sample   = (action == hicdf_pkg::ACT_SAMPLE);
  assign status.empty       = (loaded == '0) || (total == '0);
  assign status.search_done = (lo >= hi);
  assign status.div_more    = (dcnt != DCNT_W'(FRACTION_BITS - 1));
  assign status.out_free    = out_free;

  // cumulative store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.op == hicdf_pkg::OP_UPDATE && action == hicdf_pkg::ACT_APPEND && !full) begin
      store[loaded[IDX_W-1:0]] <= sum_sat;
    end
    rdata <= store[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total  <= '0;
      loaded <= '0;
    end else if (ctrl.op == hicdf_pkg::OP_UPDATE) begin
      case (action)
        hicdf_pkg::ACT_CLEAR: begin
          total  <= '0;
          loaded <= '0;
        end
        hicdf_pkg::ACT_APPEND: begin
          if (!full) begin
            total  <= sum_sat;
            loaded <= loaded + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      action  <= action_in;
      count   <= count_in;
      uniform <= uniform_in;
    end
    case (ctrl.op)
      hicdf_pkg::OP_MUL_LO: begin
        acc <= SUM_W'(product >> 16);
        lo  <= '0;
        hi  <= IDX_W'(loaded - 1'b1);
      end
      hicdf_pkg::OP_MUL_HI: begin
        s <= SUM_W'(hi_sum >> 16);
      end
      hicdf_pkg::OP_READ_MID: begin
        mid <= mid_c;
      end
      hicdf_pkg::OP_CMP_MID: begin
        if (rdata <= s) begin
          lo <= mid;
        end else begin
          hi <= mid - 1'b1;
        end
      end
      hicdf_pkg::OP_LOAD_BASE: begin
        base <= (lo == '0) ? '0 : rdata;
      end
      hicdf_pkg::OP_LOAD_WIDTH: begin
        width <= width_c;
        rem   <= rem_c;
        q     <= '0;
        dcnt  <= '0;
        ok    <= (width_c != '0) && (rem_c < width_c);
      end
      hicdf_pkg::OP_DIV_STEP: begin
        if (rem_sh >= {1'b0, width}) begin
          rem <= rem_diff[SUM_W-1:0];
          q   <= {q[FRACTION_BITS-2:0], 1'b1};
        end else begin
          rem <= rem_sh[SUM_W-1:0];
          q   <= {q[FRACTION_BITS-2:0], 1'b0};
        end
        dcnt <= dcnt + 1'b1;
      end
      default: ;
    endcase
  end

  // result register; refills in the cycle the old item is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.op == hicdf_pkg::OP_EMIT && out_free) begin
      out_valid <= 1'b1;
    end else if (ctrl.op == hicdf_pkg::OP_EMIT_EMPTY && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == hicdf_pkg::OP_EMIT && out_free) begin
      out_index    <= hicdf_pkg::OUT_INDEX_W'(lo);
      out_fraction <= ok ? hicdf_pkg::OUT_FRAC_W'(q) : '0;
      out_empty    <= 1'b0;
    end else if (ctrl.op == hicdf_pkg::OP_EMIT_EMPTY && out_free) begin
      out_index    <= '0;
      out_fraction <= '0;
      out_empty    <= 1'b1;
    end
  end

endmodule

[rtl/core/histogram_inverse_cdf_sampler_unit.sv]
// Histogram inverse-CDF sampler.
// Items arrive on the request channel (valid/ready) with an action code:
//   clear empties the table, append adds one bin count and stores the running
//   sum, sample draws one bin index plus a 16-bit in-bin fraction from a
//   uniform 32-bit value. Only samples produce a result item.
// One item is worked on at a time; request.ready is high only when the
// sequencer sits at its fetch step.
// Steps per item: clear and append run fetch, decode and update; a sample on
// an empty table runs fetch, decode, check and the empty emit step; any other
// sample runs fetch, decode, check, both multiply steps, a binary search of at
// most ceil(log2(bins loaded)) probes (each a midpoint read from the cumulative
// memory's registered read port, then a compare), the base and width loads, the
// restoring divider at one fraction bit per cycle, and the emit step.
// Results sit in an output register; a stalled receiver holds the sequencer
// at its emit step, while a waiting result does not block the next fetch.
// Reset (synchronous, active high) empties the table and drops any pending
// result. The cumulative memory needs no clearing pass.
// Depends on hicdf_pkg, hicdf_ifs, hicdf_seq and hicdf_datapath.
module histogram_inverse_cdf_sampler_unit #(
  parameter int MAX_BINS      = hicdf_pkg::DEF_MAX_BINS,
  parameter int FRACTION_BITS = hicdf_pkg::DEF_FRACTION_BITS
) (
  input logic         clk,
  input logic         rst,
  hicdf_in_if.sink    request,
  hicdf_out_if.source result
);

  hicdf_pkg::ctrl_t   ctrl;
  hicdf_pkg::status_t status;
  logic               seq_ready;

  assign request.ready = seq_ready;

  hicdf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (request.valid),
    .status   (status),
    .ctrl     (ctrl),
    .ready    (seq_ready)
  );

  hicdf_datapath #(
    .MAX_BINS      (MAX_BINS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .action_in    (request.action),
    .count_in     (request.bin_count),
    .uniform_in   (request.uniform_value),
    .out_valid    (result.valid),
    .out_ready    (result.ready),
    .out_index    (result.bin_index),
    .out_fraction (result.bin_fraction),
    .out_empty    (result.empty_table)
  );

endmodule

[verif/tb_histogram_inverse_cdf_sampler_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for histogram_inverse_cdf_sampler_unit: a local model of the
// cumulative table predicts every draw and checks it field by field.
// Depends on hicdf_pkg, hicdf_ifs and the sampler RTL.
module tb_histogram_inverse_cdf_sampler_unit;

  localparam int ACT_W = hicdf_pkg::ACTION_W;
  localparam int CNT_W = hicdf_pkg::COUNT_W;
  localparam int UNI_W = hicdf_pkg::UNIFORM_W;
  localparam int SUM_W = hicdf_pkg::SUM_W;
  localparam int IDX_W = hicdf_pkg::OUT_INDEX_W;
  localparam int FRC_W = hicdf_pkg::OUT_FRAC_W;
  localparam int NBINS = hicdf_pkg::DEF_MAX_BINS;

  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    logic [FRC_W-1:0] frac;
    logic             empty;
  } draw_t;

  logic clk = 1'b0;
  logic rst;

  always #5 clk = ~clk;

  hicdf_in_if  req_ch();
  hicdf_out_if res_ch();

  histogram_inverse_cdf_sampler_unit u_dut (
    .clk(clk),
    .rst(rst),
    .request(req_ch),
    .result(res_ch)
  );

  // model of the table
  logic [SUM_W-1:0] cum_sums [NBINS];
  int unsigned      bins_in_table;
  logic [SUM_W-1:0] table_total;
  draw_t            expected_draws[$];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned draws_checked;
  bit          gaps_on;
  int unsigned burst_left;
  int unsigned hold_cycles;

  function automatic logic [63:0] lower_sum(input int unsigned k);
    return (k == 0) ? 64'd0 : 64'(cum_sums[k-1]);
  endfunction

  function automatic void apply_item(input logic [ACT_W-1:0] action,
                                     input logic [CNT_W-1:0] count,
                                     input logic [UNI_W-1:0] r);
    logic [63:0] sum, part_hi, part_lo, scaled, base, width, rem, quo;
    int unsigned lo, hi, mid;
    draw_t d;
    case (action)
      hicdf_pkg::ACT_CLEAR: begin
        bins_in_table = 0;
        table_total = '0;
      end
      hicdf_pkg::ACT_APPEND: begin
        if (bins_in_table < NBINS) begin
          sum = 64'(table_total) + 64'(count);
          if (sum > 64'(hicdf_pkg::SUM_MAX)) sum = 64'(hicdf_pkg::SUM_MAX);
          table_total = sum[SUM_W-1:0];
          cum_sums[bins_in_table] = sum[SUM_W-1:0];
          bins_in_table++;
        end
      end
      hicdf_pkg::ACT_SAMPLE: begin
        if (bins_in_table == 0 || table_total == '0) begin
          d = '{index: '0, frac: '0, empty: 1'b1};
        end else begin
          // floor(r * total / 2^32), split in 16-bit halves of r
          part_hi = 64'(table_total) * 64'(r[31:16]);
          part_lo = 64'(table_total) * 64'(r[15:0]);
          scaled = (part_hi + (part_lo >> 16)) >> 16;
          lo = 0;
          hi = bins_in_table - 1;
          while (lo < hi) begin
            mid = (lo + hi + 1) >> 1;
            if (lower_sum(mid) <= scaled) lo = mid;
            else hi = mid - 1;
          end
          base = lower_sum(lo);
          width = 64'(cum_sums[lo]) - base;
          rem = scaled - base;
          quo = '0;
          if (width != 0 && rem < width) begin
            for (int i = 0; i < hicdf_pkg::DEF_FRACTION_BITS; i++) begin
              rem = rem << 1;
              quo = quo << 1;
              if (rem >= width) begin
                rem = rem - width;
                quo[0] = 1'b1;
              end
            end
          end
          d = '{index: lo[IDX_W-1:0], frac: quo[FRC_W-1:0], empty: 1'b0};
        end
        expected_draws = {expected_draws, d};
      end
      default: ;
    endcase
  endfunction

  function automatic logic [CNT_W-1:0] pick_count(input int unsigned flavor);
    case (flavor)
      0: return $urandom;
      1: return $urandom_range(0, 15);
      2: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1000) : 32'd0;
      default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : $urandom;
    endcase
  endfunction

  function automatic logic [UNI_W-1:0] pick_uniform();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  task automatic idle_sender(input int unsigned cycles);
    req_ch.valid <= 1'b0;
    req_ch.action <= ACT_W'($urandom);
    req_ch.bin_count <= $urandom;
    req_ch.uniform_value <= $urandom;
    repeat (cycles) @(posedge clk);
  endtask

  task automatic send_item(input logic [ACT_W-1:0] action,
                           input logic [CNT_W-1:0] count,
                           input logic [UNI_W-1:0] r);
    req_ch.valid <= 1'b1;
    req_ch.action <= action;
    req_ch.bin_count <= count;
    req_ch.uniform_value <= r;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    items_sent++;
    apply_item(action, count, r);
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      idle_sender($urandom_range(1, 6));
    end else if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  task automatic wait_drain();
    idle_sender(1);
    while (expected_draws.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: random modes, plus a long hold-off when requested
  initial begin
    int unsigned mode, mode_left;
    mode_left = 0;
    mode = 0;
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        res_ch.ready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 120);
        end
        mode_left--;
        case (mode)
          0, 1: res_ch.ready <= 1'b1;
          2: res_ch.ready <= ($urandom_range(0, 3) != 0);
          default: res_ch.ready <= ($urandom_range(0, 9) < 3);
        endcase
      end
    end
  end

  always @(posedge clk) begin : check_draws
    draw_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (expected_draws.size() == 0) begin
        $display("%0t: unexpected result index %0d frac %0d empty %0b", $time,
                 res_ch.bin_index, res_ch.bin_fraction, res_ch.empty_table);
        errors++;
      end else begin
        want = expected_draws.pop_front();
        draws_checked++;
        if (res_ch.bin_index !== want.index) begin
          $display("%0t: bin_index expected %0d actual %0d", $time, want.index,
                   res_ch.bin_index);
          errors++;
        end
        if (res_ch.bin_fraction !== want.frac) begin
          $display("%0t: bin_fraction expected %0d actual %0d", $time, want.frac,
                   res_ch.bin_fraction);
          errors++;
        end
        if (res_ch.empty_table !== want.empty) begin
          $display("%0t: empty_table expected %0b actual %0b", $time, want.empty,
                   res_ch.empty_table);
          errors++;
        end
      end
    end
  end

  // empty table: nothing loaded, then only zero-count bins; unused code is ignored
  task automatic test_empty_table();
    send_item(hicdf_pkg::ACT_SAMPLE, $urandom, $urandom);
    send_item(ACT_UNUSED, '1, '1);
    send_item(hicdf_pkg::ACT_CLEAR, '0, '0);
    send_item(hicdf_pkg::ACT_APPEND, '0, $urandom);
    send_item(hicdf_pkg::ACT_APPEND, '0, $urandom);
    send_item(hicdf_pkg::ACT_SAMPLE, $urandom, '1);
    wait_drain();
  endtask

  // widest and narrowest counts and uniform values
  task automatic test_extremes();
    send_item(hicdf_pkg::ACT_CLEAR, $urandom, $urandom);
    send_item(hicdf_pkg::ACT_APPEND, '1, '0);
    send_item(hicdf_pkg::ACT_APPEND, '0, '1);
    send_item(hicdf_pkg::ACT_APPEND, 32'd1, $urandom);
    send_item(hicdf_pkg::ACT_APPEND, '1, $urandom);
    send_item(hicdf_pkg::ACT_SAMPLE, $urandom, '0);
    send_item(hicdf_pkg::ACT_SAMPLE, $urandom, '1);
    send_item(hicdf_pkg::ACT_SAMPLE, $urandom, 32'h8000_0000);
    send_item(hicdf_pkg::ACT_SAMPLE, $urandom, 32'd1);
    wait_drain();
  endtask

  // scaled value landing exactly on a bin boundary gives fraction zero
  task automatic test_bin_edges();
    send_item(hicdf_pkg::ACT_CLEAR, $urandom, $urandom);
    repeat (4) send_item(hicdf_pkg::ACT_APPEND, 32'd1, $urandom);
    send_item(hicdf_pkg::ACT_SAMPLE, $urandom, 32'h4000_0000);
    send_item(hicdf_pkg::ACT_SAMPLE, $urandom, 32'hC000_0000);
    wait_drain();
  endtask

  // receiver holds off long enough that the block backs up into its input
  task automatic test_output_stall();
    send_item(hicdf_pkg::ACT_CLEAR, $urandom, $urandom);
    repeat (8) send_item(hicdf_pkg::ACT_APPEND, $urandom_range(1, 5000), $urandom);
    hold_cycles = 300;
    repeat (12) send_item(hicdf_pkg::ACT_SAMPLE, $urandom, $urandom);
    wait_drain();
  endtask

  // fill all bins, push past capacity, then draw across the whole range
  task automatic test_full_table();
    send_item(hicdf_pkg::ACT_CLEAR, $urandom, $urandom);
    repeat (NBINS)
      send_item(hicdf_pkg::ACT_APPEND, pick_count($urandom_range(0, 3)), $urandom);
    repeat (4) send_item(hicdf_pkg::ACT_APPEND, $urandom, $urandom);
    send_item(hicdf_pkg::ACT_SAMPLE, $urandom, '0);
    send_item(hicdf_pkg::ACT_SAMPLE, $urandom, '1);
    repeat (40) send_item(hicdf_pkg::ACT_SAMPLE, $urandom, pick_uniform());
    wait_drain();
  endtask

  // load/draw sequences with random content, some stray unused codes
  task automatic test_random_sequences();
    int unsigned counted, n_app, n_smp, flavor;
    counted = 0;
    while (counted < 740) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 3) != 0) begin
        send_item(hicdf_pkg::ACT_CLEAR, $urandom, $urandom);
        counted++;
      end
      case ($urandom_range(0, 15))
        0, 1: n_app = 0;
        2: n_app = $urandom_range(100, 300);
        default: n_app = $urandom_range(1, 24);
      endcase
      flavor = $urandom_range(0, 3);
      repeat (n_app) begin
        send_item(hicdf_pkg::ACT_APPEND, pick_count(flavor), $urandom);
        counted++;
      end
      n_smp = $urandom_range(1, 10);
      repeat (n_smp) begin
        if ($urandom_range(0, 9) == 0) send_item(ACT_UNUSED, $urandom, $urandom);
        send_item(hicdf_pkg::ACT_SAMPLE, $urandom, pick_uniform());
        counted++;
      end
    end
    gaps_on = 1'b1;
    wait_drain();
  endtask

  initial begin
    errors = 0;
    items_sent = 0;
    draws_checked = 0;
    burst_left = 0;
    hold_cycles = 0;
    gaps_on = 1'b1;
    bins_in_table = 0;
    table_total = '0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.action <= hicdf_pkg::ACT_CLEAR;
    req_ch.bin_count <= '0;
    req_ch.uniform_value <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_extremes();
    test_bin_edges();
    test_output_stall();
    test_full_table();
    test_random_sequences();

    $display("Sent %0d items and checked %0d draws: empty table, extremes, bin edges,",
             items_sent, draws_checked);
    $display("output hold-off, full table with overflow appends, random load/draw runs.");
    if (errors == 0) begin
      $display("tb_histogram_inverse_cdf_sampler_unit: done, clean");
    end else begin
      $display("tb_histogram_inverse_cdf_sampler_unit: done, errors");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Timeout with %0d draws still outstanding", expected_draws.size());
    $display("tb_histogram_inverse_cdf_sampler_unit: done, errors");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/hicdf_pkg.sv
rtl/core/hicdf_ifs.sv
rtl/core/hicdf_seq.sv
rtl/core/hicdf_datapath.sv
rtl/core/histogram_inverse_cdf_sampler_unit.sv
verif/tb_histogram_inverse_cdf_sampler_unit.sv
